/* design/usp_pkg.sv */
// Types, constants and helper functions shared by the UTF-8 safe percent escaper.
package usp_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    ACT_RAW,
    ACT_ESC_LEAD,
    ACT_ESC_ALL,
    ACT_HOLD
  } action_e;

  localparam logic [7:0]  CharPercent  = 8'h25;
  localparam logic [20:0] CpMax        = 21'h10ffff;
  localparam logic [20:0] SurrLo       = 21'h00d800;
  localparam logic [20:0] SurrHi       = 21'h00dfff;
  localparam logic [20:0] Min2         = 21'h000080;
  localparam logic [20:0] Min3         = 21'h000800;
  localparam logic [20:0] Min4         = 21'h010000;
  localparam logic [7:0]  HexDigits [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = HexDigits[nib];
  endfunction

  function automatic logic is_unsafe(input logic [20:0] cp);
    is_unsafe = (cp < 21'h20) || (cp == 21'h7f) ||
                (cp >= 21'h80 && cp <= 21'h9f) ||
                (cp == 21'h2028) || (cp == 21'h2029) ||
                (cp == 21'h200e) || (cp == 21'h200f) ||
                (cp >= 21'h202a && cp <= 21'h202e) ||
                (cp >= 21'h2066 && cp <= 21'h2069);
  endfunction

endpackage

/* design/utf8_safe_percent_escaper.sv */
// UTF-8 validating percent escaper: byte in, raw or %XX-escaped bytes out.
//
//  channel  | dir | tdata         | tuser    | tlast
//  s_axis   | in  | in_byte [7:0] | -        | in_last
//  m_axis   | out | out_byte[7:0] | run_last | text_end
//
// One shared decode unit judges the sequence at the current position and a
// sequencer emits one output byte per cycle from it unless the output stalls.
// A new input byte is taken only in ST_IDLE, once all output bytes of the
// previous one have been generated; output stalls stretch the wait.
// The last output byte of a word waits in a hold register until the word
// closes, so it can carry run_last. Reset empties all held bytes.
module utf8_safe_percent_escaper
  import usp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] run_last
  output logic       m_axis_tlast
);

  state_e      state_q, state_d;
  logic [7:0]  buf_q [4];
  logic [7:0]  buf_d [4];
  logic [7:0]  pend_q [3];
  logic [7:0]  pend_d [3];
  logic [1:0]  pend_cnt_q, pend_cnt_d;
  logic [2:0]  n_q, n_d;
  logic [2:0]  pos_q, pos_d;
  logic [1:0]  grp_q, grp_d;
  logic [1:0]  sub_q, sub_d;
  logic        last_q, last_d;
  logic [7:0]  hold_q, hold_d;
  logic        hold_vld_q, hold_vld_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_run_q, out_run_d;
  logic        out_end_q, out_end_d;
  logic        out_vld_q, out_vld_d;

  logic [7:0]  w [4];
  logic [2:0]  avail;
  logic [2:0]  need;
  logic [20:0] lead_bits;
  logic [20:0] cp;
  logic        bad;
  logic        malformed;
  action_e     act;
  logic [2:0]  grp_len;
  logic [7:0]  cur_byte;
  logic [7:0]  gen_byte;
  logic        out_free;
  logic        gen_ok;

  // decode unit: judge the sequence that starts at pos_q
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      w[k] = buf_q[pos_q[1:0] + 2'(k)];
    end
    avail = n_q - pos_q;
    if (w[0][7] == 1'b0) begin
      need = 3'd1;
      lead_bits = {14'd0, w[0][6:0]};
    end else if (w[0][7:5] == 3'b110) begin
      need = 3'd2;
      lead_bits = {16'd0, w[0][4:0]};
    end else if (w[0][7:4] == 4'b1110) begin
      need = 3'd3;
      lead_bits = {17'd0, w[0][3:0]};
    end else if (w[0][7:3] == 5'b11110) begin
      need = 3'd4;
      lead_bits = {18'd0, w[0][2:0]};
    end else begin
      need = 3'd0;
      lead_bits = '0;
    end
    case (need)
      3'd2:    cp = {10'd0, w[0][4:0], w[1][5:0]};
      3'd3:    cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
      3'd4:    cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
      default: cp = lead_bits;
    endcase
    bad = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < need && 3'(k) < avail && w[k][7:6] != 2'b10) begin
        bad = 1'b1;
      end
    end
    malformed = (need == 3'd2 && cp < Min2) || (need == 3'd3 && cp < Min3) ||
                (need == 3'd4 && cp < Min4) || (cp > CpMax) ||
                (cp >= SurrLo && cp <= SurrHi);
    if (w[0] == CharPercent || need == 3'd0) begin
      act = ACT_ESC_LEAD;
    end else if (need == 3'd1) begin
      act = is_unsafe(cp) ? ACT_ESC_ALL : ACT_RAW;
    end else if (bad) begin
      act = ACT_ESC_LEAD;
    end else if (avail < need) begin
      act = last_q ? ACT_ESC_LEAD : ACT_HOLD;
    end else if (malformed) begin
      act = ACT_ESC_LEAD;
    end else begin
      act = is_unsafe(cp) ? ACT_ESC_ALL : ACT_RAW;
    end
    grp_len = (act == ACT_RAW || act == ACT_ESC_ALL) ? need : 3'd1;
    cur_byte = w[grp_q];
    case (sub_q)
      2'd0:    gen_byte = (act == ACT_RAW) ? cur_byte : CharPercent;
      2'd1:    gen_byte = hex_char(cur_byte[7:4]);
      default: gen_byte = hex_char(cur_byte[3:0]);
    endcase
  end

  assign out_free = !out_vld_q || m_axis_tready;
  assign gen_ok   = !hold_vld_q || out_free;

  always_comb begin
    state_d    = state_q;
    buf_d      = buf_q;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    n_d        = n_q;
    pos_d      = pos_q;
    grp_d      = grp_q;
    sub_d      = sub_q;
    last_d     = last_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_byte_d = out_byte_q;
    out_run_d  = out_run_q;
    out_end_d  = out_end_q;
    out_vld_d  = out_free ? 1'b0 : out_vld_q;
    s_axis_tready = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            buf_d[i] = (2'(i) < pend_cnt_q) ? pend_q[i] : s_axis_tdata;
          end
          buf_d[3]   = s_axis_tdata;
          n_d        = {1'b0, pend_cnt_q} + 3'd1;
          pend_cnt_d = '0;
          pos_d      = '0;
          grp_d      = '0;
          sub_d      = '0;
          last_d     = s_axis_tlast;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pos_q >= n_q || act == ACT_HOLD) begin
          // close the word: keep an incomplete sequence and release the held byte marked as its last
          if (act == ACT_HOLD && pos_q < n_q) begin
            for (int i = 0; i < 3; i++) begin
              pend_d[i] = w[i];
            end
            pend_cnt_d = avail[1:0];
          end
          if (!hold_vld_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_byte_d = hold_q;
            out_run_d  = 1'b1;
            out_end_d  = last_q;
            out_vld_d  = 1'b1;
            hold_vld_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end else if (gen_ok) begin
          if (hold_vld_q) begin
            out_byte_d = hold_q;
            out_run_d  = 1'b0;
            out_end_d  = 1'b0;
            out_vld_d  = 1'b1;
          end
          hold_d     = gen_byte;
          hold_vld_d = 1'b1;
          if (act != ACT_RAW && sub_q != 2'd2) begin
            sub_d = sub_q + 2'd1;
          end else begin
            sub_d = '0;
            if ({1'b0, grp_q} + 3'd1 >= grp_len) begin
              grp_d = '0;
              pos_d = pos_q + grp_len;
            end else begin
              grp_d = grp_q + 2'd1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_cnt_q <= '0;
      n_q        <= '0;
      pos_q      <= '0;
      grp_q      <= '0;
      sub_q      <= '0;
      last_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pend_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      pend_cnt_q <= pend_cnt_d;
      n_q        <= n_d;
      pos_q      <= pos_d;
      grp_q      <= grp_d;
      sub_q      <= sub_d;
      last_q     <= last_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    hold_q     <= hold_d;
    out_byte_q <= out_byte_d;
    out_run_q  <= out_run_d;
    out_end_q  <= out_end_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_run_q;
  assign m_axis_tlast  = out_end_q;

endmodule
